/* hdl/lrucc_pkg.sv */
// Shared types, constants and key folding for the LRU cache cost counter.
// No dependencies; imported by every other file of the block.
`default_nettype none

package lrucc_pkg;

    localparam int MAX_NAME_CHARS = 8;
    localparam int CFG_W          = 6;
    localparam int ADDR_W         = 3;

    localparam logic [31:0] HIT_COST  = 32'd1;
    localparam logic [31:0] MISS_COST = 32'd5;

    // word index of the register, taken from paddr[ADDR_W-1]
    localparam logic REG_CACHE_SIZE = 1'b0;

    typedef struct packed {
        logic [63:0] city_name;
        logic        first_of_list;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] total_cost;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic key_we;
        logic age_we;
        logic valid_set;
        logic valid_clr;
    } store_cmd_t;

    // upper-case a..z, drop bytes past MAX_NAME_CHARS
    function automatic logic [63:0] fold_key(input logic [63:0] raw);
        logic [63:0] folded;
        logic [7:0]  c;
        folded = '0;
        for (int b = 0; b < 8; b++)
        begin
            c = raw[63-8*b -: 8];
            if (b >= MAX_NAME_CHARS)
            begin
                c = '0;
            end
            if (c >= 8'h61 && c <= 8'h7A)
            begin
                c = c - 8'h20;
            end
            folded[63-8*b -: 8] = c;
        end
        return folded;
    endfunction

endpackage

`default_nettype wire

/* hdl/lrucc_store.sv */
// Entry storage: key memory, recency memory and per-entry valid flops.
// Depends on lrucc_pkg. Reads are registered, one read and one write per cycle.
`default_nettype none

module lrucc_store #(
    parameter int CAPACITY = 32,
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lrucc_pkg::store_cmd_t  cmd,
    input  logic [IDX_W-1:0]       rd_addr,
    input  logic [IDX_W-1:0]       wr_addr,
    input  logic [63:0]            key_wdata,
    input  logic [IDX_W-1:0]       age_wdata,
    output logic [63:0]            key_rdata,
    output logic [IDX_W-1:0]       age_rdata,
    output logic                   valid_rdata
);
    import lrucc_pkg::*;

    logic [63:0]      key_mem [CAPACITY];
    logic [IDX_W-1:0] age_mem [CAPACITY];

    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [63:0]         key_rd_reg;
    logic [IDX_W-1:0]    age_rd_reg;
    logic                valid_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.key_we)
        begin
            key_mem[wr_addr] <= key_wdata;
        end
        if (cmd.age_we)
        begin
            age_mem[wr_addr] <= age_wdata;
        end
        key_rd_reg <= key_mem[rd_addr];
        age_rd_reg <= age_mem[rd_addr];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.valid_clr)
        begin
            valid_next = '0;
        end
        if (cmd.valid_set)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            valid_rd_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            valid_rd_reg <= valid_reg[rd_addr];
        end
    end

    assign key_rdata   = key_rd_reg;
    assign age_rdata   = age_rd_reg;
    assign valid_rdata = valid_rd_reg;

endmodule

`default_nettype wire

/* hdl/lru_cache_cost_counter.sv */
// LRU cache cost counter. One request at a time; a single compare/age unit
// sweeps the key and recency memories one entry per cycle.
// A request scans used = min(cache_size, CAPACITY) entries, sweeps recency over all
// CAPACITY entries unless used is 0, and returns; new requests wait for idle.
// Reset: cache empty, total zero, cache_size zero; no clearing pass.
`default_nettype none

module lru_cache_cost_counter #(
    parameter int CAPACITY = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lrucc_pkg::ADDR_W-1:0]      paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  lrucc_pkg::req_t                   req_data,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output lrucc_pkg::rsp_t                   rsp_data
);
    import lrucc_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = ($clog2(CAPACITY + 1) > CFG_W) ? $clog2(CAPACITY + 1) : CFG_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    state_t           state_reg, state_next;
    logic [CFG_W-1:0] cache_size_reg, cache_size_next;
    logic [63:0]      key_reg, key_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0] hit_age_reg, hit_age_next;
    logic             empty_reg, empty_next;
    logic [IDX_W-1:0] empty_idx_reg, empty_idx_next;
    logic [IDX_W-1:0] best_age_reg, best_age_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [IDX_W-1:0] limit_reg, limit_next;
    logic             fill_reg, fill_next;
    logic [31:0]      cost_reg, cost_next;
    logic             rsp_vld_reg, rsp_vld_next;
    rsp_t             rsp_reg, rsp_next;

    store_cmd_t       cmd;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic [IDX_W-1:0] age_wdata;
    logic [63:0]      key_rdata;
    logic [IDX_W-1:0] age_rdata;
    logic             valid_rdata;

    logic [CNT_W-1:0] cache_ext, used;
    logic [32:0]      cost_sum;
    logic [31:0]      cost_sat;

    lrucc_store #(.CAPACITY(CAPACITY)) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .wr_addr     (wr_addr),
        .key_wdata   (key_reg),
        .age_wdata   (age_wdata),
        .key_rdata   (key_rdata),
        .age_rdata   (age_rdata),
        .valid_rdata (valid_rdata)
    );

    assign cache_ext = CNT_W'(cache_size_reg);
    assign used      = (cache_ext > CAP_CNT) ? CAP_CNT : cache_ext;
    assign cost_sum  = {1'b0, cost_reg} + {1'b0, (found_reg ? HIT_COST : MISS_COST)};
    assign cost_sat  = cost_sum[32] ? '1 : cost_sum[31:0];

    assign pready    = 1'b1;
    assign prdata    = (paddr[ADDR_W-1] == REG_CACHE_SIZE) ? 32'(cache_size_reg) : '0;
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_vld_reg;
    assign rsp_data  = rsp_reg;

    always_comb
    begin
        state_next      = state_reg;
        cache_size_next = cache_size_reg;
        key_next        = key_reg;
        cnt_next        = cnt_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = cnt_reg[IDX_W-1:0];
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_age_next    = hit_age_reg;
        empty_next      = empty_reg;
        empty_idx_next  = empty_idx_reg;
        best_age_next   = best_age_reg;
        best_idx_next   = best_idx_reg;
        slot_next       = slot_reg;
        limit_next      = limit_reg;
        fill_next       = fill_reg;
        cost_next       = cost_reg;
        rsp_vld_next    = rsp_vld_reg;
        rsp_next        = rsp_reg;
        cmd             = '0;
        rd_addr         = cnt_reg[IDX_W-1:0];
        wr_addr         = chk_idx_reg;
        age_wdata       = '0;

        if (psel && penable && pwrite && paddr[ADDR_W-1] == REG_CACHE_SIZE)
        begin
            cache_size_next = pwdata[CFG_W-1:0];
        end

        if (rsp_vld_reg && !rsp_stall)
        begin
            rsp_vld_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    key_next      = fold_key(req_data.city_name);
                    cnt_next      = '0;
                    found_next    = 1'b0;
                    empty_next    = 1'b0;
                    best_age_next = '0;
                    best_idx_next = '0;
                    if (req_data.first_of_list)
                    begin
                        cmd.valid_clr = 1'b1;
                        cost_next     = '0;
                    end
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // check the entry read last cycle
                if (chk_vld_reg)
                begin
                    if (valid_rdata && key_rdata == key_reg && !found_reg)
                    begin
                        found_next   = 1'b1;
                        hit_idx_next = chk_idx_reg;
                        hit_age_next = age_rdata;
                    end
                    if (!valid_rdata && !empty_reg)
                    begin
                        empty_next     = 1'b1;
                        empty_idx_next = chk_idx_reg;
                    end
                    if (age_rdata >= best_age_reg)
                    begin
                        best_age_next = age_rdata;
                        best_idx_next = chk_idx_reg;
                    end
                end
                if (cnt_reg < used)
                begin
                    chk_vld_next = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                end
                else if (!chk_vld_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                cost_next = cost_sat;
                cnt_next  = '0;
                if (found_reg)
                begin
                    slot_next  = hit_idx_reg;
                    limit_next = hit_age_reg;
                    fill_next  = 1'b0;
                    state_next = ST_UPDATE;
                end
                else if (used == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    if (empty_reg)
                    begin
                        slot_next = empty_idx_reg;
                        fill_next = 1'b1;
                    end
                    else
                    begin
                        slot_next  = best_idx_reg;
                        limit_next = best_age_reg;
                        fill_next  = 1'b0;
                    end
                    wr_addr       = slot_next;
                    cmd.key_we    = 1'b1;
                    cmd.valid_set = 1'b1;
                    state_next    = ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                // recency sweep over every entry, in use or not
                if (chk_vld_reg)
                begin
                    if (chk_idx_reg == slot_reg)
                    begin
                        cmd.age_we = 1'b1;
                        age_wdata  = '0;
                    end
                    else if (valid_rdata && (fill_reg || age_rdata < limit_reg))
                    begin
                        cmd.age_we = 1'b1;
                        age_wdata  = age_rdata + 1'b1;
                    end
                end
                if (cnt_reg < CAP_CNT)
                begin
                    chk_vld_next = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                end
                else if (!chk_vld_reg)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!rsp_vld_reg || !rsp_stall)
                begin
                    rsp_vld_next        = 1'b1;
                    rsp_next.hit        = found_reg;
                    rsp_next.total_cost = cost_reg;
                    state_next          = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cache_size_reg <= '0;
            cost_reg       <= '0;
            chk_vld_reg    <= 1'b0;
            rsp_vld_reg    <= 1'b0;
            found_reg      <= 1'b0;
            empty_reg      <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cache_size_reg <= cache_size_next;
            cost_reg       <= cost_next;
            chk_vld_reg    <= chk_vld_next;
            rsp_vld_reg    <= rsp_vld_next;
            found_reg      <= found_next;
            empty_reg      <= empty_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        chk_idx_reg   <= chk_idx_next;
        hit_idx_reg   <= hit_idx_next;
        hit_age_reg   <= hit_age_next;
        empty_idx_reg <= empty_idx_next;
        best_age_reg  <= best_age_next;
        best_idx_reg  <= best_idx_next;
        slot_reg      <= slot_next;
        limit_reg     <= limit_next;
        fill_reg      <= fill_next;
        rsp_reg       <= rsp_next;
    end

endmodule

`default_nettype wire

/* hdl/lrucc_checker.sv */
// Port-level checks for lru_cache_cost_counter, bound to the top level.
// Depends on lrucc_pkg for the result type.
`default_nettype none

module lrucc_props (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_stall,
    input logic            rsp_valid,
    input logic            rsp_stall,
    input lrucc_pkg::rsp_t rsp_data
);
    import lrucc_pkg::*;

    // an accepted request leaves the block busy in the cycle after
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted with block not busy next cycle");

    // every access adds cost, so a result never reports zero
    a_cost_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.total_cost != 32'd0)
        else $error("result with zero total cost");

    // a fresh result only appears after the block was busy
    a_rsp_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result appeared without work in progress");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp_data))
        else $error("result changed while stalled");

endmodule

bind lru_cache_cost_counter lrucc_props u_lrucc_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);

`default_nettype wire
